// ===== sv/rusi_pkg.sv =====
`timescale 1ns / 1ps

package rusi_pkg;

  // Word formats of the ports.
  localparam int COORD_BITS = 16;
  localparam int COORD_FRAC = 12;
  localparam int PARAM_BITS = 32;
  localparam int OUT_FRAC   = PARAM_BITS / 2;

  // Internal widths, all exact for the full input range.
  localparam int PROD_W = 2 * COORD_BITS;
  localparam int A_W    = 2 * COORD_BITS;
  localparam int BH_W   = A_W + 1;
  localparam int DISC_W = 2 * BH_W;
  localparam int RAD_W  = 4 * COORD_BITS;
  localparam int ROOT_W = 2 * COORD_BITS;
  localparam int NUM_W  = ROOT_W + 2;
  localparam int MAG_W  = NUM_W - 1 + OUT_FRAC;
  localparam int DIV_W  = (MAG_W > PARAM_BITS) ? MAG_W : PARAM_BITS + 1;
  localparam int HI_W   = DIV_W - PARAM_BITS;
  localparam int CMP_W  = (HI_W > A_W) ? HI_W : A_W;

  // Flags that travel beside the quotient through the divider cells.
  localparam int FLAG_W = 5;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic signed [COORD_BITS-1:0] origin_z;
    logic signed [COORD_BITS-1:0] dir_x;
    logic signed [COORD_BITS-1:0] dir_y;
    logic signed [COORD_BITS-1:0] dir_z;
  } ray_in_t;

  typedef struct packed {
    logic                         hit;
    logic signed [PARAM_BITS-1:0] t_near;
    logic signed [PARAM_BITS-1:0] t_far;
  } ray_out_t;

endpackage

// ===== sv/rusi_front.sv =====
`timescale 1ns / 1ps

module rusi_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  rusi_pkg::ray_in_t                     in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_hit,
  output logic [rusi_pkg::A_W-1:0]              out_a,
  output logic signed [rusi_pkg::BH_W-1:0]      out_bh,
  output logic [rusi_pkg::RAD_W-1:0]            out_rad
);

  localparam logic signed [rusi_pkg::BH_W-1:0] ONE_SQ =
    rusi_pkg::BH_W'(1) << (2 * rusi_pkg::COORD_FRAC);

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [rusi_pkg::PROD_W-1:0] dd_r [3];
  logic signed [rusi_pkg::PROD_W-1:0] do_r [3];
  logic signed [rusi_pkg::PROD_W-1:0] oo_r [3];

  logic [rusi_pkg::A_W-1:0]          a2_r, a3_r, a4_r;
  logic signed [rusi_pkg::BH_W-1:0]  bh2_r, bh3_r, bh4_r, c2_r;
  logic signed [rusi_pkg::DISC_W-1:0] bb3_r, ac3_r;
  logic [rusi_pkg::RAD_W-1:0]        rad4_r;
  logic                              hit4_r;

  logic signed [rusi_pkg::BH_W-1:0]   a_sum, bh_sum, c_sum;
  logic signed [rusi_pkg::DISC_W-1:0] disc;
  logic                               hit_nxt;

  // Each stage moves when it is empty or its word leaves this cycle.
  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Stage 1: the nine coordinate products.
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      dd_r[0] <= in_data.dir_x * in_data.dir_x;
      dd_r[1] <= in_data.dir_y * in_data.dir_y;
      dd_r[2] <= in_data.dir_z * in_data.dir_z;
      do_r[0] <= in_data.dir_x * in_data.origin_x;
      do_r[1] <= in_data.dir_y * in_data.origin_y;
      do_r[2] <= in_data.dir_z * in_data.origin_z;
      oo_r[0] <= in_data.origin_x * in_data.origin_x;
      oo_r[1] <= in_data.origin_y * in_data.origin_y;
      oo_r[2] <= in_data.origin_z * in_data.origin_z;
    end
  end

  // Stage 2: dot products d.d, d.o and o.o minus one.
  assign a_sum  = rusi_pkg::BH_W'(dd_r[0]) + rusi_pkg::BH_W'(dd_r[1])
                + rusi_pkg::BH_W'(dd_r[2]);
  assign bh_sum = rusi_pkg::BH_W'(do_r[0]) + rusi_pkg::BH_W'(do_r[1])
                + rusi_pkg::BH_W'(do_r[2]);
  assign c_sum  = rusi_pkg::BH_W'(oo_r[0]) + rusi_pkg::BH_W'(oo_r[1])
                + rusi_pkg::BH_W'(oo_r[2]) - ONE_SQ;

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      a2_r  <= a_sum[rusi_pkg::A_W-1:0];
      bh2_r <= bh_sum;
      c2_r  <= c_sum;
    end
  end

  // Stage 3: the two products of the reduced discriminant.
  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      bb3_r <= bh2_r * bh2_r;
      ac3_r <= $signed({1'b0, a2_r}) * c2_r;
      a3_r  <= a2_r;
      bh3_r <= bh2_r;
    end
  end

  // Stage 4: a positive discriminant and a nonzero d.d decide the hit.
  assign disc    = bb3_r - ac3_r;
  assign hit_nxt = !disc[rusi_pkg::DISC_W-1] && (disc != '0) && (a3_r != '0);

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      rad4_r <= disc[rusi_pkg::RAD_W-1:0];
      hit4_r <= hit_nxt;
      a4_r   <= a3_r;
      bh4_r  <= bh3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_hit   = hit4_r;
  assign out_a     = a4_r;
  assign out_bh    = bh4_r;
  assign out_rad   = rad4_r;

endmodule

// ===== sv/rusi_sqrt_cell.sv =====
`timescale 1ns / 1ps

module rusi_sqrt_cell #(
  parameter int ROOT_W = rusi_pkg::ROOT_W,
  parameter int RAD_W  = rusi_pkg::RAD_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ROOT_W:0]   in_rem,
  input  logic [ROOT_W-1:0] in_root,
  input  logic [RAD_W-1:0]  in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ROOT_W:0]   out_rem,
  output logic [ROOT_W-1:0] out_root,
  output logic [RAD_W-1:0]  out_rad,
  output logic [SIDE_W-1:0] out_side
);

  logic              v_r;
  logic [ROOT_W:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [RAD_W-1:0]  rad_r;
  logic [SIDE_W-1:0] side_r;

  logic [ROOT_W+2:0] part, trial, diff;
  logic              take;

  // One root digit: bring down two radicand bits, try root*4+1.
  assign part     = {in_rem, in_rad[RAD_W-1 -: 2]};
  assign trial    = {1'b0, in_root, 2'b01};
  assign diff     = part - trial;
  assign take     = part >= trial;
  assign rem_nxt  = take ? diff[ROOT_W:0] : part[ROOT_W:0];
  assign root_nxt = {in_root[ROOT_W-2:0], take};

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= in_rad << 2;
      side_r <= in_side;
    end
  end

  assign out_valid = v_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_rad   = rad_r;
  assign out_side  = side_r;

endmodule

// ===== sv/rusi_div_cell.sv =====
`timescale 1ns / 1ps

module rusi_div_cell #(
  parameter int A_W    = rusi_pkg::A_W,
  parameter int Q_W    = rusi_pkg::PARAM_BITS,
  parameter int SIDE_W = rusi_pkg::FLAG_W
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0][A_W-1:0]       in_rem,
  input  logic [1:0][Q_W-1:0]       in_word,
  input  logic [A_W-1:0]            in_a,
  input  logic [SIDE_W-1:0]         in_side,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0][A_W-1:0]       out_rem,
  output logic [1:0][Q_W-1:0]       out_word,
  output logic [A_W-1:0]            out_a,
  output logic [SIDE_W-1:0]         out_side
);

  logic                v_r;
  logic [1:0][A_W-1:0] rem_r, rem_nxt;
  logic [1:0][Q_W-1:0] word_r, word_nxt;
  logic [A_W-1:0]      a_r;
  logic [SIDE_W-1:0]   side_r;

  // One quotient bit per lane. The word shifts dividend bits out at the
  // top and quotient bits in at the bottom.
  always_comb begin
    logic [A_W:0] part;
    logic [A_W:0] diff;
    logic         take;
    for (int l = 0; l < 2; l++) begin
      part        = {in_rem[l], in_word[l][Q_W-1]};
      diff        = part - {1'b0, in_a};
      take        = part >= {1'b0, in_a};
      rem_nxt[l]  = take ? diff[A_W-1:0] : part[A_W-1:0];
      word_nxt[l] = {in_word[l][Q_W-2:0], take};
    end
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_r  <= rem_nxt;
      word_r <= word_nxt;
      a_r    <= in_a;
      side_r <= in_side;
    end
  end

  assign out_valid = v_r;
  assign out_rem   = rem_r;
  assign out_word  = word_r;
  assign out_a     = a_r;
  assign out_side  = side_r;

endmodule

// ===== sv/ray_unit_sphere_intersect.sv =====
`timescale 1ns / 1ps

// Ray against the unit sphere at the origin, fully pipelined: one ray word
// is accepted per clock when the result side does not stall. A ray passes
// through the front end, the chain of square-root cells, one root bit each,
// the numerator stage, the chain of divider cells, one quotient bit each for
// both crossings at once, and the output register. Each stage holds its own
// valid bit, so bubbles close up under back-pressure and a word waiting at
// the output does not stop the input. Inputs are Q4.12, results Q16.16,
// truncated toward zero and saturated; a miss or a tangent ray reports
// hit low with both parameters zero.
module ray_unit_sphere_intersect (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rusi_pkg::ray_in_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rusi_pkg::ray_out_t  out_data
);

  localparam int ROOT_W = rusi_pkg::ROOT_W;
  localparam int RAD_W  = rusi_pkg::RAD_W;
  localparam int A_W    = rusi_pkg::A_W;
  localparam int BH_W   = rusi_pkg::BH_W;
  localparam int PB     = rusi_pkg::PARAM_BITS;
  localparam int NUM_W  = rusi_pkg::NUM_W;
  localparam int DIV_W  = rusi_pkg::DIV_W;
  localparam int CMP_W  = rusi_pkg::CMP_W;
  localparam int SQ_SIDE_W = 1 + A_W + BH_W;

  localparam logic [PB-1:0] T_MAX = {1'b0, {(PB-1){1'b1}}};
  localparam logic [PB-1:0] T_MIN = {1'b1, {(PB-1){1'b0}}};

  // Front end: products, dot products and discriminant.
  logic                   fe_valid, fe_hit;
  logic [A_W-1:0]         fe_a;
  logic signed [BH_W-1:0] fe_bh;
  logic [RAD_W-1:0]       fe_rad;

  // Square-root chain wiring.
  logic                 sq_v   [ROOT_W+1];
  logic                 sq_rdy [ROOT_W+1];
  logic [ROOT_W:0]      sq_rem [ROOT_W+1];
  logic [ROOT_W-1:0]    sq_root[ROOT_W+1];
  logic [RAD_W-1:0]     sq_rad [ROOT_W+1];
  logic [SQ_SIDE_W-1:0] sq_side[ROOT_W+1];

  // Divider chain wiring.
  logic                          dv_v   [PB+1];
  logic                          dv_rdy [PB+1];
  logic [1:0][A_W-1:0]           dv_rem [PB+1];
  logic [1:0][PB-1:0]            dv_word[PB+1];
  logic [A_W-1:0]                dv_a   [PB+1];
  logic [rusi_pkg::FLAG_W-1:0]   dv_side[PB+1];

  rusi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (fe_valid),
    .out_ready (sq_rdy[0]),
    .out_hit   (fe_hit),
    .out_a     (fe_a),
    .out_bh    (fe_bh),
    .out_rad   (fe_rad)
  );

  assign sq_v[0]    = fe_valid;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = fe_rad;
  assign sq_side[0] = {fe_hit, fe_a, fe_bh};

  // One cell per root bit, most significant first.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    rusi_sqrt_cell #(
      .ROOT_W (ROOT_W),
      .RAD_W  (RAD_W),
      .SIDE_W (SQ_SIDE_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_v[k]),
      .in_ready  (sq_rdy[k]),
      .in_rem    (sq_rem[k]),
      .in_root   (sq_root[k]),
      .in_rad    (sq_rad[k]),
      .in_side   (sq_side[k]),
      .out_valid (sq_v[k+1]),
      .out_ready (sq_rdy[k+1]),
      .out_rem   (sq_rem[k+1]),
      .out_root  (sq_root[k+1]),
      .out_rad   (sq_rad[k+1]),
      .out_side  (sq_side[k+1])
    );
  end

  // Numerator stage: -Bh -/+ sqrt(D), split into sign and scaled magnitude.
  logic                   sq_hit;
  logic [A_W-1:0]         sq_a;
  logic signed [BH_W-1:0] sq_bh;
  logic                   pv_r, prep_rdy, pv_hit_r;
  logic [1:0]             pv_neg_r, pv_ovf_r;
  logic [1:0][A_W-1:0]    pv_rem_r;
  logic [1:0][PB-1:0]     pv_word_r;
  logic [A_W-1:0]         pv_a_r;

  logic signed [NUM_W-1:0] neg_bh, root_s;
  logic signed [NUM_W-1:0] num     [2];
  logic [1:0]              neg_nxt, ovf_nxt;
  logic [1:0][A_W-1:0]     rem_nxt;
  logic [1:0][PB-1:0]      word_nxt;

  assign {sq_hit, sq_a, sq_bh} = sq_side[ROOT_W];
  assign sq_rdy[ROOT_W] = prep_rdy;

  assign neg_bh = -NUM_W'(sq_bh);
  assign root_s = $signed({2'b00, sq_root[ROOT_W]});
  assign num[0] = neg_bh - root_s;
  assign num[1] = neg_bh + root_s;

  always_comb begin
    logic signed [NUM_W-1:0] absv;
    logic [DIV_W-1:0]        scaled;
    logic [CMP_W-1:0]        hi;
    for (int l = 0; l < 2; l++) begin
      neg_nxt[l]  = num[l][NUM_W-1];
      absv        = neg_nxt[l] ? -num[l] : num[l];
      scaled      = DIV_W'(absv[NUM_W-2:0]) << rusi_pkg::OUT_FRAC;
      hi          = CMP_W'(scaled[DIV_W-1:PB]);
      ovf_nxt[l]  = hi >= CMP_W'(sq_a);
      rem_nxt[l]  = hi[A_W-1:0];
      word_nxt[l] = scaled[PB-1:0];
    end
  end

  assign prep_rdy = !pv_r || dv_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (prep_rdy) begin
      pv_r <= sq_v[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (prep_rdy && sq_v[ROOT_W]) begin
      pv_hit_r  <= sq_hit;
      pv_neg_r  <= neg_nxt;
      pv_ovf_r  <= ovf_nxt;
      pv_rem_r  <= rem_nxt;
      pv_word_r <= word_nxt;
      pv_a_r    <= sq_a;
    end
  end

  assign dv_v[0]    = pv_r;
  assign dv_rem[0]  = pv_rem_r;
  assign dv_word[0] = pv_word_r;
  assign dv_a[0]    = pv_a_r;
  assign dv_side[0] = {pv_hit_r, pv_neg_r, pv_ovf_r};

  // One cell per quotient bit, both crossings side by side.
  for (genvar k = 0; k < PB; k++) begin : g_div
    rusi_div_cell #(
      .A_W    (A_W),
      .Q_W    (PB),
      .SIDE_W (rusi_pkg::FLAG_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv_v[k]),
      .in_ready  (dv_rdy[k]),
      .in_rem    (dv_rem[k]),
      .in_word   (dv_word[k]),
      .in_a      (dv_a[k]),
      .in_side   (dv_side[k]),
      .out_valid (dv_v[k+1]),
      .out_ready (dv_rdy[k+1]),
      .out_rem   (dv_rem[k+1]),
      .out_word  (dv_word[k+1]),
      .out_a     (dv_a[k+1]),
      .out_side  (dv_side[k+1])
    );
  end

  // Output register: sign, saturation and the no-hit zeroing.
  logic               dv_hit;
  logic [1:0]         dv_neg, dv_ovf;
  logic [1:0][PB-1:0] t_nxt;
  logic               out_valid_r, out_rdy;
  rusi_pkg::ray_out_t out_data_r;

  assign {dv_hit, dv_neg, dv_ovf} = dv_side[PB];

  always_comb begin
    logic [PB-1:0] q;
    for (int l = 0; l < 2; l++) begin
      q = dv_word[PB][l];
      if (!dv_hit) begin
        t_nxt[l] = '0;
      end else if (!dv_neg[l]) begin
        t_nxt[l] = (dv_ovf[l] || q[PB-1]) ? T_MAX : q;
      end else begin
        t_nxt[l] = (dv_ovf[l] || (q[PB-1] && (q[PB-2:0] != '0))) ? T_MIN : -q;
      end
    end
  end

  assign out_rdy      = !out_valid_r || out_ready;
  assign dv_rdy[PB]   = out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= dv_v[PB];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && dv_v[PB]) begin
      out_data_r.hit    <= dv_hit;
      out_data_r.t_near <= $signed(t_nxt[0]);
      out_data_r.t_far  <= $signed(t_nxt[1]);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // A word that reports no hit carries zero parameters.
  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.t_near == '0 && out_data.t_far == '0)
    else $error("miss word carries nonzero parameters");

  // The near crossing never lies beyond the far one.
  a_near_first : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.t_near <= out_data.t_far)
    else $error("near parameter above far parameter");

  // With the output register empty, every stage is free to take a word.
  a_open_pipe : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output register is empty");
`endif

endmodule

// ===== sim/ray_crossing_checker.sv =====
`timescale 1ns / 1ps

module ray_crossing_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  rusi_pkg::ray_in_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  rusi_pkg::ray_out_t out_data,
  output int                 fail_count,
  output int                 pending
);

  typedef logic signed [127:0] wide_s_t;
  typedef logic [127:0]        wide_u_t;

  rusi_pkg::ray_out_t crossings_q[$];

  // Floor square root of a non-negative wide value, one root bit at a time.
  function automatic wide_u_t floor_root(wide_u_t val);
    wide_u_t root;
    wide_u_t trial;
    root = '0;
    for (int k = 63; k >= 0; k--) begin
      trial = root | (wide_u_t'(1) << k);
      if (trial * trial <= val) root = trial;
    end
    return root;
  endfunction

  // Signed numerator over a positive denominator, scaled to Q16.16,
  // truncated toward zero and saturated to the parameter range.
  function automatic logic [rusi_pkg::PARAM_BITS-1:0] fixed_quotient(
    wide_s_t num, wide_s_t den);
    logic    neg;
    wide_u_t mag;
    wide_u_t quo;
    wide_u_t lim;
    neg = num < 0;
    mag = neg ? wide_u_t'(-num) : wide_u_t'(num);
    mag = mag << rusi_pkg::OUT_FRAC;
    quo = mag / wide_u_t'(den);
    lim = wide_u_t'(1) << (rusi_pkg::PARAM_BITS - 1);
    if (!neg) begin
      if (quo >= lim) return {1'b0, {(rusi_pkg::PARAM_BITS-1){1'b1}}};
      return quo[rusi_pkg::PARAM_BITS-1:0];
    end
    if (quo > lim) quo = lim;
    return rusi_pkg::PARAM_BITS'(-quo);
  endfunction

  // Expected crossings for one ray word.
  function automatic rusi_pkg::ray_out_t predict_crossings(rusi_pkg::ray_in_t r);
    wide_s_t            o [3];
    wide_s_t            d [3];
    wide_s_t            a, bh, c, disc, s, nb;
    rusi_pkg::ray_out_t res;
    o[0] = $signed(r.origin_x);
    o[1] = $signed(r.origin_y);
    o[2] = $signed(r.origin_z);
    d[0] = $signed(r.dir_x);
    d[1] = $signed(r.dir_y);
    d[2] = $signed(r.dir_z);
    a  = '0;
    bh = '0;
    c  = -(wide_s_t'(1) <<< (2 * rusi_pkg::COORD_FRAC));
    for (int i = 0; i < 3; i++) begin
      a  = a + d[i] * d[i];
      bh = bh + d[i] * o[i];
      c  = c + o[i] * o[i];
    end
    disc = bh * bh - a * c;
    res = '0;
    // Miss, tangent and zero direction all report no hit with zero parameters.
    if (disc <= 0 || a == 0) return res;
    s  = wide_s_t'(floor_root(wide_u_t'(disc)));
    nb = -bh;
    res.hit    = 1'b1;
    res.t_near = fixed_quotient(nb - s, a);
    res.t_far  = fixed_quotient(nb + s, a);
    return res;
  endfunction

  // Predict on every accepted ray word and compare every accepted result word.
  always @(posedge clk) begin
    rusi_pkg::ray_out_t want;
    int                 errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) crossings_q.push_back(predict_crossings(in_data));
      if (out_valid && out_ready) begin
        if (crossings_q.size() == 0) begin
          $error("result word with no ray waiting");
          errs++;
        end else begin
          want = crossings_q.pop_front();
          if (out_data.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, out_data.hit);
            errs++;
          end
          if (out_data.t_near !== want.t_near) begin
            $error("t_near: expected %0d, actual %0d", want.t_near, out_data.t_near);
            errs++;
          end
          if (out_data.t_far !== want.t_far) begin
            $error("t_far: expected %0d, actual %0d", want.t_far, out_data.t_far);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= crossings_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_RANDOM = 850;
  localparam int QUIET_TAIL = 150;
  localparam int LATENCY    = 4 + 2 * rusi_pkg::COORD_BITS + 1 + rusi_pkg::PARAM_BITS + 1;
  localparam int HOLD_AT    = 300;
  localparam int HOLD_LEN   = 400;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  rusi_pkg::ray_in_t  in_data;
  logic               out_valid;
  logic               out_ready;
  rusi_pkg::ray_out_t out_data;
  int                 fail_count;
  int                 pending;
  int                 rays_sent;
  logic               quiet;
  logic               hold_done;

  ray_unit_sphere_intersect DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  ray_crossing_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic rusi_pkg::ray_in_t make_ray(int ox, int oy, int oz,
                                                 int dx, int dy, int dz);
    rusi_pkg::ray_in_t r;
    r.origin_x = ox[15:0];
    r.origin_y = oy[15:0];
    r.origin_z = oz[15:0];
    r.dir_x    = dx[15:0];
    r.dir_y    = dy[15:0];
    r.dir_z    = dz[15:0];
    return r;
  endfunction

  // Mostly rays aimed near the sphere, so hits are common; the rest spans
  // the full coordinate range.
  function automatic rusi_pkg::ray_in_t random_ray();
    rusi_pkg::ray_in_t r;
    int                ox, oy, oz;
    if ($urandom_range(0, 9) < 3) begin
      r = rusi_pkg::ray_in_t'({$urandom, $urandom, $urandom});
    end else begin
      ox = $urandom_range(0, 24576) - 12288;
      oy = $urandom_range(0, 24576) - 12288;
      oz = $urandom_range(0, 24576) - 12288;
      r = make_ray(ox, oy, oz,
                   -ox + $urandom_range(0, 8192) - 4096,
                   -oy + $urandom_range(0, 8192) - 4096,
                   -oz + $urandom_range(0, 8192) - 4096);
    end
    return r;
  endfunction

  // Offer one ray word and wait until it is taken.
  task automatic send_ray(rusi_pkg::ray_in_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rays_sent++;
    @(negedge clk);
  endtask

  // Result side: random stall bursts and one long hold-off to fill the pipe.
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && rays_sent >= HOLD_AT) begin
        out_ready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_done = 1'b1;
        out_ready = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        repeat ($urandom_range(0, 20)) begin
          @(negedge clk);
          if (!hold_done && rays_sent >= HOLD_AT) break;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    rays_sent = 0;
    quiet     = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed rays: zero and extreme words, a hit from the center, a tangent,
    // a miss, a zero direction, and both saturation directions.
    send_ray(make_ray(0, 0, 0, 0, 0, 0));
    send_ray(make_ray(-32768, -32768, -32768, -32768, -32768, -32768));
    send_ray(make_ray(32767, 32767, 32767, 32767, 32767, 32767));
    send_ray(make_ray(-32768, 32767, -32768, 32767, -32768, 32767));
    send_ray(make_ray(32767, -32768, 32767, -32768, 32767, -32768));
    send_ray(make_ray(-32768, -32768, -32768, 32767, 32767, 32767));
    send_ray(make_ray(0, 0, 0, 4096, 0, 0));
    send_ray(make_ray(0, 0, 0, 0, -4096, 0));
    send_ray(make_ray(0, 0, -8192, 0, 0, 4096));
    send_ray(make_ray(4096, 0, -8192, 0, 0, 4096));
    send_ray(make_ray(8192, 0, -8192, 0, 0, 4096));
    send_ray(make_ray(1234, -2222, 777, 0, 0, 0));
    send_ray(make_ray(-32768, 0, 0, 1, 0, 0));
    send_ray(make_ray(-32768, 0, 0, -1, 0, 0));
    send_ray(make_ray(0, 0, 0, 1, 0, 0));
    send_ray(make_ray(0, 0, 0, -1, -1, -1));
    send_ray(make_ray(2048, 2048, 2048, -32768, 32767, -1));

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM - QUIET_TAIL) quiet = 1'b1;
      send_ray(random_ray());
    end
    in_valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/rusi_pkg.sv
sv/rusi_front.sv
sv/rusi_sqrt_cell.sv
sv/rusi_div_cell.sv
sv/ray_unit_sphere_intersect.sv
sim/ray_crossing_checker.sv
sim/tb_top.sv
